// ===== rtl/apsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types, widths and helpers of the all-pairs shortest path block.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int unsigned DEF_NODES = 8;
    localparam int unsigned MAX_NODES = 8;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned DIST_W    = 30;
    localparam int unsigned ADDR_W    = $clog2(MAX_NODES * MAX_NODES);
    localparam int unsigned FIELDS_W  = 2 * IDX_W + DIST_W;
    localparam int unsigned TDATA_W   = ((FIELDS_W + 7) / 8) * 8;

    // bit positions inside tdata, lowest field first
    localparam int unsigned SRC_LSB  = 0;
    localparam int unsigned DST_LSB  = IDX_W;
    localparam int unsigned DIST_LSB = 2 * IDX_W;

    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PIVOT,
        ST_RELAX,
        ST_EMIT
    } apsp_state_t;

    // controller to datapath
    typedef struct packed {
        logic              load_we;
        logic              piv_rd;
        logic              rlx_rd;
        logic              out_rd;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic [IDX_W-1:0]  src;
        logic [IDX_W-1:0]  dst;
        logic              last;
    } apsp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } apsp_status_t;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [IDX_W-1:0] r,
        input logic [IDX_W-1:0] c,
        input int unsigned      nodes
    );
        int unsigned lin;
        lin = r * nodes + c;
        return lin[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/apsp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module apsp_ram #(
    parameter int unsigned WIDTH = 30,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/apsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_ctrl
// Sequencer: load phase, k/i/j relaxation sweep, then row-major readout.
// ----------------------------------------------------------------------------
module apsp_ctrl
    import apsp_pkg::*;
#(
    parameter int unsigned NODES = DEF_NODES,
    localparam int unsigned IW   = $clog2(NODES)
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tlast,
    output logic         s_tready,
    input  apsp_status_t status,
    output apsp_cmd_t    cmd
);

    localparam logic [IW-1:0] IDX_END = IW'(NODES - 1);

    apsp_state_t   state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic          issue;
    logic          j_end, i_end, k_end;

    assign j_end = (j_reg == IDX_END);
    assign i_end = (i_reg == IDX_END);
    assign k_end = (k_reg == IDX_END);
    assign issue = (state_reg == ST_EMIT) && status.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_PIVOT;
                end
            end
            ST_PIVOT:
            begin
                state_next = ST_RELAX;
            end
            ST_RELAX:
            begin
                if (j_end)
                begin
                    state_next = (i_end && k_end) ? ST_EMIT : ST_PIVOT;
                end
            end
            ST_EMIT:
            begin
                if (issue && i_end && j_end)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // loop counters
    always_comb
    begin
        k_next = k_reg;
        i_next = i_reg;
        j_next = j_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                k_next = '0;
                i_next = '0;
                j_next = '0;
            end
            ST_RELAX:
            begin
                j_next = j_end ? '0 : j_reg + 1'b1;
                if (j_end)
                begin
                    i_next = i_end ? '0 : i_reg + 1'b1;
                    if (i_end)
                    begin
                        k_next = k_end ? '0 : k_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    j_next = j_end ? '0 : j_reg + 1'b1;
                    if (j_end)
                    begin
                        i_next = i_end ? '0 : i_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready    = 1'b0;
        cmd         = '0;
        cmd.src     = IDX_W'(i_reg);
        cmd.dst     = IDX_W'(j_reg);
        cmd.last    = i_end && j_end;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready    = 1'b1;
                cmd.load_we = s_tvalid;
            end
            ST_PIVOT:
            begin
                cmd.piv_rd = 1'b1;
                cmd.addr_a = cell_addr(IDX_W'(i_reg), IDX_W'(k_reg), NODES);
            end
            ST_RELAX:
            begin
                cmd.rlx_rd = 1'b1;
                cmd.addr_a = cell_addr(IDX_W'(i_reg), IDX_W'(j_reg), NODES);
                cmd.addr_b = cell_addr(IDX_W'(k_reg), IDX_W'(j_reg), NODES);
            end
            ST_EMIT:
            begin
                cmd.out_rd = issue;
                cmd.addr_a = cell_addr(IDX_W'(i_reg), IDX_W'(j_reg), NODES);
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/apsp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_dp
// Distance memory, compare-add relaxation unit and output register.
// ----------------------------------------------------------------------------
module apsp_dp
    import apsp_pkg::*;
#(
    parameter int unsigned NODES = DEF_NODES,
    localparam int unsigned DEPTH = NODES * NODES,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  apsp_cmd_t          cmd,
    output apsp_status_t       status,
    input  logic [TDATA_W-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    localparam logic [IDX_W:0] NODES_LIM = (IDX_W + 1)'(NODES);

    logic [DIST_W-1:0] rd_a, rd_b;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DIST_W-1:0] ram_wdata;

    logic [IDX_W-1:0]  in_row, in_col;
    logic [DIST_W-1:0] in_dist;
    logic              in_range;

    logic              piv_pend_reg, rlx_pend_reg, out_pend_reg;
    logic [AW-1:0]     rlx_addr_reg;
    logic [DIST_W-1:0] pivot_reg;
    logic [IDX_W-1:0]  pend_src_reg, pend_dst_reg;
    logic              pend_last_reg;

    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_src_reg, out_dst_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic              out_last_reg;

    logic [DIST_W:0]   via;
    logic              shorter;

    assign in_row   = s_tdata[SRC_LSB +: IDX_W];
    assign in_col   = s_tdata[DST_LSB +: IDX_W];
    assign in_dist  = s_tdata[DIST_LSB +: DIST_W];
    assign in_range = ({1'b0, in_row} < NODES_LIM) && ({1'b0, in_col} < NODES_LIM);

    // path through k: 31-bit sum, a strict improvement always fits in 30 bits
    assign via     = {1'b0, pivot_reg} + {1'b0, rd_b};
    assign shorter = ({1'b0, rd_a} > via);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = rlx_addr_reg;
        ram_wdata = via[DIST_W-1:0];
        if (cmd.load_we)
        begin
            ram_we    = in_range;
            ram_waddr = AW'(cell_addr(in_row, in_col, NODES));
            ram_wdata = in_dist;
        end
        else if (rlx_pend_reg)
        begin
            ram_we = shorter;
        end
    end

    apsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (cmd.addr_a[AW-1:0]),
        .rdata_a (rd_a),
        .raddr_b (cmd.addr_b[AW-1:0]),
        .rdata_b (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piv_pend_reg  <= 1'b0;
            rlx_pend_reg  <= 1'b0;
            out_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            piv_pend_reg  <= cmd.piv_rd;
            rlx_pend_reg  <= cmd.rlx_rd;
            out_pend_reg  <= cmd.out_rd;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rlx_addr_reg  <= cmd.addr_a[AW-1:0];
        pend_src_reg  <= cmd.src;
        pend_dst_reg  <= cmd.dst;
        pend_last_reg <= cmd.last;
        if (piv_pend_reg)
        begin
            pivot_reg <= rd_a;
        end
        if (out_pend_reg)
        begin
            out_src_reg  <= pend_src_reg;
            out_dst_reg  <= pend_dst_reg;
            out_dist_reg <= rd_a;
            out_last_reg <= pend_last_reg;
        end
    end

    always_comb
    begin
        priority if (out_pend_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // a read may issue when its data will find the output register free
    assign status.out_free = !out_pend_reg && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(TDATA_W - FIELDS_W){1'b0}}, out_dist_reg, out_dst_reg, out_src_reg};

endmodule

// ===== rtl/all_pairs_shortest_path.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path
// Floyd-Warshall shortest paths over a NODES x NODES distance matrix.
// ----------------------------------------------------------------------------
// Load the matrix one entry per transfer (any order, entries with row or col
// of NODES or more are dropped); the transfer with tlast starts the solve.
// Loading accepts one entry per cycle. The solve uses one compare-add unit
// fed by a two-read-port memory: each (k, i) pair does one pivot read of
// entry (i, k), then relaxes entry (i, j) through k for every j. The matrix
// then streams out in row-major order, tlast on the last entry; a new entry
// is read only once the previous one has reached the output register. The
// solved matrix stays in memory as the starting point of the next load; the
// input side is ready only while loading. 1073741823 means unreachable.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path
    import apsp_pkg::*;
#(
    parameter int unsigned NODES = DEF_NODES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // row[2:0], col[5:3], dist_in[35:6], zero pad
    input  logic               s_tlast,   // last_in
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // src_node[2:0], dst_node[5:3], dist_out[35:6], zero pad
    output logic               m_tlast    // last_out
);

    apsp_cmd_t    cmd;
    apsp_status_t status;

    apsp_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    apsp_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/apsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_checker
// Port-level checks of the shortest path block, bound to the top level.
// ----------------------------------------------------------------------------
module apsp_checker
    import apsp_pkg::*;
#(
    parameter int unsigned NODES = DEF_NODES
) (
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    localparam logic [IDX_W-1:0] IDX_END = IDX_W'(NODES - 1);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // the closing load transfer starts the solve, input side closes
    a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still ready after final load transfer");

    // the final result is the bottom right corner
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[SRC_LSB +: IDX_W] == IDX_END &&
                                m_tdata[DST_LSB +: IDX_W] == IDX_END)
        else $error("last result not at final matrix entry");

    // emitted indices stay inside the matrix and padding stays zero
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[SRC_LSB +: IDX_W] <= IDX_END &&
                     m_tdata[DST_LSB +: IDX_W] <= IDX_END &&
                     m_tdata[TDATA_W-1:FIELDS_W] == '0)
        else $error("result index out of range or padding set");

endmodule

bind all_pairs_shortest_path apsp_checker #(.NODES(NODES)) u_checker (.*);
